// ----- sv/pds_pkg.sv -----
// Shared widths, register indexes, reset values and control types of the PLL divider search.
package pds_pkg;

    // Field widths.
    localparam int REF_W    = 17;
    localparam int M_W      = 9;
    localparam int N_W      = 7;
    localparam int R_W      = 3;
    localparam int FREQ_W   = 20;
    localparam int CFG_IDX_W = 3;

    // Internal widths.
    localparam int NCNT_W   = N_W + 1;          // N counter, holds max_n + 1
    localparam int MP2_W    = M_W + 1;          // M + 2
    localparam int FOUT_W   = REF_W + MP2_W;    // ref * (M + 2)
    localparam int DIV_NUM_W = 36;              // (target * (N + 2)) << R, plus rounding term
    localparam int DIV_DEN_W = REF_W;

    // Divider offset of the PLL (M + 2, N + 2).
    localparam int OFFSET = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REF_KHZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_M   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_N   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_R   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VCO = 3'd4;

    // Reset values of the registers.
    localparam logic [REF_W-1:0]  RST_REF_KHZ = 17'd14318;
    localparam logic [M_W-1:0]    RST_MAX_M   = 9'd127;
    localparam logic [N_W-1:0]    RST_MAX_N   = 7'd31;
    localparam logic [R_W-1:0]    RST_MAX_R   = 3'd3;
    localparam logic [FREQ_W-1:0] RST_MIN_VCO = 20'd135000;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [REF_W-1:0]  ref_khz;
        logic [M_W-1:0]    max_m;
        logic [N_W-1:0]    max_n;
        logic [R_W-1:0]    max_r;
        logic [FREQ_W-1:0] min_vco;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new request, clear search state
        logic r_inc;     // step the post-divider exponent
        logic div1_go;   // start the M division
        logic m_load;    // keep M + 2 from the quotient
        logic div2_go;   // start the output frequency division
        logic eval;      // compare the error against the best so far
        logic n_inc;     // move to the next N
        logic finish;    // present the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r_more;    // exponent still too small for the VCO range
        logic n_ok;      // N within range and reference nonzero
        logic div_done;  // quotient valid this cycle
        logic m_ok;      // M lies within 0..max_m
    } stat_t;

endpackage

// ----- sv/pds_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
module pds_divider #(
    parameter int NUM_W = pds_pkg::DIV_NUM_W,
    parameter int DEN_W = pds_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], fits};
            rem_next  = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Operand and quotient registers need no reset.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ----- sv/pds_datapath.sv -----
// Search datapath: exponent and N counters, operand build, shared divider, best candidate.
module pds_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pds_pkg::cfg_t               cfg,
    input  pds_pkg::cmd_t               cmd,
    output pds_pkg::stat_t              stat,
    input  logic [pds_pkg::FREQ_W-1:0]  target_khz,
    output logic [pds_pkg::M_W-1:0]     m_value,
    output logic [pds_pkg::N_W-1:0]     n_value,
    output logic [pds_pkg::R_W-1:0]     r_value,
    output logic [pds_pkg::FREQ_W-1:0]  error_khz,
    output logic                        found,
    output logic                        done
);

    localparam int NP2_W  = pds_pkg::NCNT_W;
    localparam int PROD_W = pds_pkg::FREQ_W + NP2_W;
    localparam int DEN2_W = NP2_W + 7;
    localparam int ERR_W  = pds_pkg::FOUT_W;

    logic [pds_pkg::FREQ_W-1:0]  target_reg;
    logic [pds_pkg::R_W-1:0]     r_reg;
    logic [pds_pkg::NCNT_W-1:0]  n_reg;
    logic [pds_pkg::MP2_W-1:0]   mp2_reg;
    logic                        found_reg;
    logic [ERR_W-1:0]            best_err_reg;
    logic [pds_pkg::M_W-1:0]     best_m_reg;
    logic [pds_pkg::N_W-1:0]     best_n_reg;

    logic [pds_pkg::M_W-1:0]     m_value_reg;
    logic [pds_pkg::N_W-1:0]     n_value_reg;
    logic [pds_pkg::R_W-1:0]     r_value_reg;
    logic [pds_pkg::FREQ_W-1:0]  error_khz_reg;
    logic                        found_out_reg;
    logic                        done_reg;

    logic [NP2_W-1:0]                  n_plus2;
    logic [PROD_W-1:0]                 prod1;
    logic [pds_pkg::DIV_NUM_W-1:0]     num1;
    logic [pds_pkg::FOUT_W-1:0]        prod2;
    logic [DEN2_W-1:0]                 den2;
    logic [pds_pkg::DIV_NUM_W-1:0]     div_num;
    logic [pds_pkg::DIV_DEN_W-1:0]     div_den;
    logic [pds_pkg::DIV_NUM_W-1:0]     quot;
    logic                              div_done;
    logic [ERR_W-1:0]                  fout;
    logic [ERR_W-1:0]                  target_ext;
    logic [ERR_W-1:0]                  err;
    logic                              better;

    // M division: ((target * (N + 2)) << R + 2 * floor(ref / 2)) / ref.
    assign n_plus2 = n_reg + NP2_W'(pds_pkg::OFFSET);
    assign prod1   = PROD_W'(target_reg) * PROD_W'(n_plus2);
    assign num1    = (pds_pkg::DIV_NUM_W'(prod1) << r_reg)
                   + pds_pkg::DIV_NUM_W'({cfg.ref_khz[pds_pkg::REF_W-1:1], 1'b0});

    // Output frequency division: ref * (M + 2) / ((N + 2) << R).
    assign prod2 = pds_pkg::FOUT_W'(cfg.ref_khz) * pds_pkg::FOUT_W'(mp2_reg);
    assign den2  = DEN2_W'(n_plus2) << r_reg;

    assign div_num = cmd.div2_go ? pds_pkg::DIV_NUM_W'(prod2) : num1;
    assign div_den = cmd.div2_go ? pds_pkg::DIV_DEN_W'(den2) : cfg.ref_khz;

    pds_divider #(
        .NUM_W(pds_pkg::DIV_NUM_W),
        .DEN_W(pds_pkg::DIV_DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (cmd.div1_go | cmd.div2_go),
        .num  (div_num),
        .den  (div_den),
        .quot (quot),
        .done (div_done)
    );

    // Absolute error of the candidate and the comparison with the best one.
    assign fout       = quot[ERR_W-1:0];
    assign target_ext = ERR_W'(target_reg);
    assign err        = (fout > target_ext) ? (fout - target_ext) : (target_ext - fout);
    assign better     = !found_reg || (err < best_err_reg);

    // Status back to the controller.
    assign stat.r_more   = (r_reg < cfg.max_r)
                        && ((ERR_W'(target_reg) << r_reg) < ERR_W'(cfg.min_vco));
    assign stat.n_ok     = (n_reg <= {1'b0, cfg.max_n}) && (cfg.ref_khz != '0);
    assign stat.div_done = div_done;
    assign stat.m_ok     = (quot >= pds_pkg::DIV_NUM_W'(pds_pkg::OFFSET))
                        && (quot <= pds_pkg::DIV_NUM_W'(cfg.max_m)
                                  + pds_pkg::DIV_NUM_W'(pds_pkg::OFFSET));

    // Search state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg     <= '0;
            n_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                r_reg     <= '0;
                n_reg     <= pds_pkg::NCNT_W'(1);
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.r_inc)
                begin
                    r_reg <= r_reg + pds_pkg::R_W'(1);
                end
                if (cmd.n_inc)
                begin
                    n_reg <= n_reg + pds_pkg::NCNT_W'(1);
                end
                if (cmd.eval && better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload of the search.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= target_khz;
        end
        if (cmd.m_load)
        begin
            mp2_reg <= quot[pds_pkg::MP2_W-1:0];
        end
        if (cmd.eval && better)
        begin
            best_err_reg <= err;
            best_m_reg   <= pds_pkg::M_W'(mp2_reg - pds_pkg::MP2_W'(pds_pkg::OFFSET));
            best_n_reg   <= n_reg[pds_pkg::N_W-1:0];
        end
    end

    // Result registers; the strobe lasts one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_out_reg <= found_reg;
            if (found_reg)
            begin
                m_value_reg   <= best_m_reg;
                n_value_reg   <= best_n_reg;
                r_value_reg   <= r_reg;
                error_khz_reg <= (best_err_reg[ERR_W-1:pds_pkg::FREQ_W] != '0)
                               ? '1 : best_err_reg[pds_pkg::FREQ_W-1:0];
            end
            else
            begin
                m_value_reg   <= '0;
                n_value_reg   <= '0;
                r_value_reg   <= '0;
                error_khz_reg <= '0;
            end
        end
    end

    assign m_value   = m_value_reg;
    assign n_value   = n_value_reg;
    assign r_value   = r_value_reg;
    assign error_khz = error_khz_reg;
    assign found     = found_out_reg;
    assign done      = done_reg;

endmodule

// ----- sv/pds_ctrl.sv -----
// Controller state machine that sequences the exponent search and the N loop.
module pds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pds_pkg::stat_t stat,
    output pds_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RSRCH = 3'd1;
    localparam logic [2:0] ST_NCHK  = 3'd2;
    localparam logic [2:0] ST_DIV1  = 3'd3;
    localparam logic [2:0] ST_MCHK  = 3'd4;
    localparam logic [2:0] ST_DIV2S = 3'd5;
    localparam logic [2:0] ST_DIV2  = 3'd6;
    localparam logic [2:0] ST_EVAL  = 3'd7;

    logic [2:0] state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RSRCH;
                end
            end
            ST_RSRCH:
            begin
                if (stat.r_more)
                begin
                    cmd.r_inc = 1'b1;
                end
                else
                begin
                    state_next = ST_NCHK;
                end
            end
            ST_NCHK:
            begin
                if (stat.n_ok)
                begin
                    cmd.div1_go = 1'b1;
                    state_next  = ST_DIV1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV1:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MCHK;
                end
            end
            ST_MCHK:
            begin
                if (stat.m_ok)
                begin
                    cmd.m_load = 1'b1;
                    state_next = ST_DIV2S;
                end
                else
                begin
                    cmd.n_inc  = 1'b1;
                    state_next = ST_NCHK;
                end
            end
            ST_DIV2S:
            begin
                cmd.div2_go = 1'b1;
                state_next  = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                cmd.n_inc  = 1'b1;
                state_next = ST_NCHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- sv/pll_divider_search_core.sv -----
// Top level of the PLL divider search: configuration registers, controller and datapath.
//
//  Channel   Signals                                      Transfer
//  request   start, busy, target_khz                      start && !busy
//  result    done, m_value, n_value, r_value,             done, one cycle
//            error_khz, found
//  config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// A request first steps the exponent R, then for each value of N runs an M division and,
// where M falls in range, an output frequency division on the shared 36-step serial divider.
// The result strobe is registered after the search ends, when busy is already low.
// Reset clears the controller and loads the register defaults; there is no clearing pass.
// The receiver cannot stall; a new request may be taken in the cycle the result shows.
module pll_divider_search_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pds_pkg::FREQ_W-1:0]         target_khz,
    output logic                               done,
    output logic [pds_pkg::M_W-1:0]            m_value,
    output logic [pds_pkg::N_W-1:0]            n_value,
    output logic [pds_pkg::R_W-1:0]            r_value,
    output logic [pds_pkg::FREQ_W-1:0]         error_khz,
    output logic                               found,
    input  logic                               cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pds_pkg::FREQ_W-1:0]         cfg_data
);

    pds_pkg::cfg_t  cfg_reg;
    pds_pkg::cmd_t  cmd;
    pds_pkg::stat_t stat;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_khz <= pds_pkg::RST_REF_KHZ;
            cfg_reg.max_m   <= pds_pkg::RST_MAX_M;
            cfg_reg.max_n   <= pds_pkg::RST_MAX_N;
            cfg_reg.max_r   <= pds_pkg::RST_MAX_R;
            cfg_reg.min_vco <= pds_pkg::RST_MIN_VCO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pds_pkg::REG_REF_KHZ: cfg_reg.ref_khz <= cfg_data[pds_pkg::REF_W-1:0];
                pds_pkg::REG_MAX_M:   cfg_reg.max_m   <= cfg_data[pds_pkg::M_W-1:0];
                pds_pkg::REG_MAX_N:   cfg_reg.max_n   <= cfg_data[pds_pkg::N_W-1:0];
                pds_pkg::REG_MAX_R:   cfg_reg.max_r   <= cfg_data[pds_pkg::R_W-1:0];
                pds_pkg::REG_MIN_VCO: cfg_reg.min_vco <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    pds_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy)
    );

    pds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .target_khz(target_khz),
        .m_value   (m_value),
        .n_value   (n_value),
        .r_value   (r_value),
        .error_khz (error_khz),
        .found     (found),
        .done      (done)
    );

    // The result strobe only appears once the search has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while search still busy");

    // A failed search reports all fields as zero.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (m_value == '0 && n_value == '0 && r_value == '0
                              && error_khz == '0))
        else $error("fields not cleared without a candidate");

    // A found candidate always has a nonzero N.
    a_found_n: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (n_value != '0))
        else $error("candidate reported with N of zero");

    // A search only begins on a request.
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("search began without a request");

    // One strobe per request, never two in a row.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule
